// ===== rtl/ir_serial_byte_receiver_top_macros.svh =====
// ----------------------------------------------------------------------------
// IR serial byte receiver assertion macros
// Shared property templates for the checker of the receiver ports.
// ----------------------------------------------------------------------------
`ifndef IR_SERIAL_BYTE_RECEIVER_TOP_MACROS_SVH
`define IR_SERIAL_BYTE_RECEIVER_TOP_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define IRSBR_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IRSBR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/irsbr_pkg.sv =====
// ----------------------------------------------------------------------------
// IR serial byte receiver package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package irsbr_pkg;

	localparam int DATA_BITS  = 8;
	localparam int BYTE_W     = 8;
	localparam int TICK_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W      = $clog2(DATA_BITS + 1);

	localparam logic [TICK_W-1:0] RST_START_DELAY = TICK_W'(12000);
	localparam logic [TICK_W-1:0] RST_BIT_PERIOD  = TICK_W'(8000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RX_ENABLE   = 2'd0,
		REG_START_DELAY = 2'd1,
		REG_BIT_PERIOD  = 2'd2,
		REG_INVERT      = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_FRAME = 1'b1
	} rx_state_t;

	typedef struct packed {
		logic              rx_enable;
		logic [TICK_W-1:0] start_delay;
		logic [TICK_W-1:0] bit_period;
		logic              invert;
		logic              abort;
	} cfg_t;

	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] data;
	} frame_res_t;

endpackage

// ===== rtl/irsbr_cfg.sv =====
// ----------------------------------------------------------------------------
// IR serial byte receiver configuration registers
// Write-only register file; flags a disable write as a frame abort.
// ----------------------------------------------------------------------------
module irsbr_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [irsbr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [irsbr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output irsbr_pkg::cfg_t                     cfg
);
	import irsbr_pkg::*;

	logic              rx_enable_q;
	logic [TICK_W-1:0] start_delay_q;
	logic [TICK_W-1:0] bit_period_q;
	logic              invert_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_enable_q   <= 1'b1;
			start_delay_q <= RST_START_DELAY;
			bit_period_q  <= RST_BIT_PERIOD;
			invert_q      <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_RX_ENABLE:   rx_enable_q   <= cfg_wdata[0];
				REG_START_DELAY: start_delay_q <= cfg_wdata[TICK_W-1:0];
				REG_BIT_PERIOD:  bit_period_q  <= cfg_wdata[TICK_W-1:0];
				REG_INVERT:      invert_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.rx_enable   = rx_enable_q;
		cfg.start_delay = start_delay_q;
		cfg.bit_period  = bit_period_q;
		cfg.invert      = invert_q;
		cfg.abort       = cfg_we && (reg_idx_t'(cfg_index) == REG_RX_ENABLE)
			&& !cfg_wdata[0];
	end

endmodule

// ===== rtl/irsbr_frame.sv =====
// ----------------------------------------------------------------------------
// IR serial byte receiver frame engine
// Start-edge detect, tick countdown and LSB-first bit assembly, one tick a cycle.
// ----------------------------------------------------------------------------
module irsbr_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick,
	input  logic                  level,
	input  irsbr_pkg::cfg_t       cfg,
	output irsbr_pkg::frame_res_t res
);
	import irsbr_pkg::*;

	rx_state_t         state_q;
	rx_state_t         state_d;
	logic              last_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] shift_q;
	logic [TICK_W-1:0] ticks_q;

	logic [TICK_W-1:0] ticks_dec;
	logic [CNT_W-1:0]  count_inc;
	logic              sample;
	logic              last_bit;
	logic              start;
	logic              rx_bit;
	logic [BYTE_W-1:0] shift_set;

	assign ticks_dec = ticks_q - 1'b1;
	assign count_inc = count_q + 1'b1;
	assign sample    = (state_q == ST_FRAME) && (ticks_dec == '0);
	assign last_bit  = (count_inc == CNT_W'(DATA_BITS));
	assign start     = (state_q == ST_IDLE) && cfg.rx_enable && !last_q && level;
	assign rx_bit    = level ^ cfg.invert;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick && start) state_d = ST_FRAME;
			end
			ST_FRAME: begin
				if (tick && sample && last_bit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (cfg.abort) state_d = ST_IDLE;
	end

	// outputs: bit positions past the byte width never match and are dropped
	always_comb begin
		for (int i = 0; i < BYTE_W; i++) begin
			shift_set[i] = shift_q[i] | (rx_bit && (32'(count_q) == i));
		end
		res.done = tick && sample && last_bit;
		res.data = shift_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b1;
			count_q <= '0;
			shift_q <= '0;
			ticks_q <= '0;
		end else if (tick) begin
			last_q <= level;
			if (start) begin
				count_q <= '0;
				shift_q <= '0;
				ticks_q <= cfg.start_delay;
			end else if (state_q == ST_FRAME) begin
				ticks_q <= sample ? cfg.bit_period : ticks_dec;
				if (sample) begin
					count_q <= count_inc;
					shift_q <= shift_set;
				end
			end
		end
	end

endmodule

// ===== rtl/ir_serial_byte_receiver_top.sv =====
// ----------------------------------------------------------------------------
// IR serial byte receiver
// Samples the receive line once per beat and assembles LSB-first bytes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------
//  in      | sink      | in_valid / in_stall  | line_level (1 bit)
//  out     | source    | out_valid / out_stall| received_byte (8 bits)
//  cfg     | sink      | cfg_we               | cfg_index, cfg_wdata
//
//  One input beat per cycle while in_stall is low; a beat is held in
//  the input register, then the frame engine updates and any finished
//  byte lands in the output register, where it shows on received_byte.
//  arst_n clears all control state and loads the register reset values.
//  in_stall rises only while a byte waits in the output register and
//  out_stall is high; the input register then holds its beat.
//
module ir_serial_byte_receiver_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// input beats
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              line_level,
	// result beats
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [irsbr_pkg::BYTE_W-1:0]      received_byte,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [irsbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [irsbr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import irsbr_pkg::*;

	cfg_t              cfg;
	frame_res_t        res;

	logic              valid_s1;
	logic              level_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              proc_ok;
	logic              tick;

	// The held beat advances whenever the output register is empty or draining.
	assign proc_ok  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !proc_ok;
	assign tick     = valid_s1 && proc_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) level_s1 <= line_level;
	end

	irsbr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	irsbr_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Output register: a new byte can only be written when the slot is free or
	// being taken, since res.done implies proc_ok.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) out_byte_q <= res.data;
	end

	assign out_valid     = out_valid_q;
	assign received_byte = out_byte_q;

endmodule

// ===== rtl/irsbr_checker.sv =====
// ----------------------------------------------------------------------------
// IR serial byte receiver port checker
// Port-level properties of the receiver, bound onto the top level.
// ----------------------------------------------------------------------------
`include "ir_serial_byte_receiver_top_macros.svh"

module irsbr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [irsbr_pkg::BYTE_W-1:0]      received_byte,
	input logic                              cfg_we,
	input logic [irsbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [irsbr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import irsbr_pkg::*;

	`IRSBR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "stalled result beat dropped")
	`IRSBR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(received_byte), "stalled result beat changed")
	`IRSBR_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall && in_valid || out_valid && out_stall, "input stalled without a blocked result")
	`IRSBR_ASSERT_IMPL(a_abort_quiet, clk, arst_n, cfg_we && (cfg_index == REG_RX_ENABLE) && !cfg_wdata[0], ##2 !$rose(out_valid), "byte emitted after receiver disable")

endmodule

bind ir_serial_byte_receiver_top irsbr_checker u_chk (.*);
